FILE: src/ctt_pkg.sv
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types, codes and character-class helpers for the character stream
// tokenizer.
// ----------------------------------------------------------------------------
package ctt_pkg;

    localparam int MAX_TOKEN_LEN = 255;
    localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;

    localparam logic [2:0] KIND_KEYWORD = 3'd0;
    localparam logic [2:0] KIND_DELIM   = 3'd1;
    localparam logic [2:0] KIND_OP      = 3'd2;
    localparam logic [2:0] KIND_IDENT   = 3'd3;
    localparam logic [2:0] KIND_NUMBER  = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    localparam logic [2:0] KW_NONE = 3'd0;
    localparam logic [2:0] KW_F    = 3'd1;
    localparam logic [2:0] KW_FO   = 3'd2;
    localparam logic [2:0] KW_FOR  = 3'd3;
    localparam logic [2:0] KW_D    = 3'd4;
    localparam logic [2:0] KW_DO   = 3'd5;

    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_0          = 8'h30;
    localparam logic [7:0] CH_9          = 8'h39;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_LT         = 8'h3C;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_GT         = 8'h3E;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_D    = 8'h64;
    localparam logic [7:0] CH_LOWER_F    = 8'h66;
    localparam logic [7:0] CH_LOWER_O    = 8'h6F;
    localparam logic [7:0] CH_LOWER_R    = 8'h72;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_IDENT  = 4'b0010,
        MODE_NUMBER = 4'b0100,
        MODE_COLON  = 4'b1000
    } scan_mode_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  value_char;
        logic [31:0] start_offset;
        logic [7:0]  length;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } entry_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z], CH_UNDERSCORE});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[CH_0:CH_9]});
    endfunction

    function automatic logic [7:0] sat_len(input logic [LEN_W-1:0] len);
        if (int'(len) > 255)
            return 8'hFF;
        else
            return 8'(len);
    endfunction

    function automatic logic [2:0] next_progress(input logic [2:0] p, input logic [7:0] c);
        if (p == KW_F && c == CH_LOWER_O)
            return KW_FO;
        else if (p == KW_FO && c == CH_LOWER_R)
            return KW_FOR;
        else if (p == KW_D && c == CH_LOWER_O)
            return KW_DO;
        else
            return KW_NONE;
    endfunction

endpackage

FILE: src/ctt_scanner.sv
// ----------------------------------------------------------------------------
// ctt_scanner
// Front end: accepts one request per cycle while the queue is not full, keeps
// the scan state and forms up to two results per request as one queue entry.
// ----------------------------------------------------------------------------
module ctt_scanner (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            action,
    input  logic [7:0]      character,
    input  logic            queue_full,
    output logic            push,
    output ctt_pkg::entry_t push_entry
);
    import ctt_pkg::*;

    scan_mode_t       mode_reg,  mode_next;
    logic [31:0]      start_reg, start_next;
    logic [LEN_W-1:0] len_reg,   len_next;
    logic [7:0]       first_reg, first_next;
    logic [2:0]       kw_reg,    kw_next;
    logic [31:0]      pos_reg,   pos_next;

    logic             accept;
    logic             flush_v, scan_v, rescan;
    result_t          pending_res, flush_res, scan_res;
    logic [LEN_W-1:0] len_grow;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign len_grow = (int'(len_reg) < MAX_TOKEN_LEN) ? len_reg + LEN_W'(1) : len_reg;

    always_comb
    begin
        pending_res = '0;
        case (mode_reg)
            MODE_IDENT:
            begin
                pending_res.kind = (kw_reg == KW_FOR || kw_reg == KW_DO) ? KIND_KEYWORD
                                                                          : KIND_IDENT;
                pending_res.value_char   = first_reg;
                pending_res.start_offset = start_reg;
                pending_res.length       = sat_len(len_reg);
            end
            MODE_NUMBER:
            begin
                pending_res.kind = (len_reg == LEN_W'(1) &&
                                    (first_reg == CH_PLUS || first_reg == CH_MINUS))
                                   ? KIND_OP : KIND_NUMBER;
                pending_res.value_char   = first_reg;
                pending_res.start_offset = start_reg;
                pending_res.length       = sat_len(len_reg);
            end
            MODE_COLON:
            begin
                pending_res.kind         = KIND_ERROR;
                pending_res.value_char   = CH_COLON;
                pending_res.start_offset = start_reg;
                pending_res.length       = 8'd1;
            end
            default:
            begin
                pending_res = '0;
            end
        endcase
    end

    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        first_next = first_reg;
        kw_next    = kw_reg;
        pos_next   = pos_reg;
        flush_v    = 1'b0;
        flush_res  = pending_res;
        scan_v     = 1'b0;
        scan_res   = '0;
        rescan     = 1'b0;

        if (action == ACT_END)
        begin
            flush_v    = (mode_reg != MODE_IDLE);
            mode_next  = MODE_IDLE;
            start_next = '0;
            len_next   = '0;
            first_next = '0;
            kw_next    = KW_NONE;
            pos_next   = '0;
        end
        else
        begin
            pos_next = pos_reg + 32'd1;
            case (mode_reg)
                MODE_IDENT:
                begin
                    if (is_letter(character) || is_digit(character))
                    begin
                        len_next = len_grow;
                        kw_next  = next_progress(kw_reg, character);
                    end
                    else
                    begin
                        flush_v = 1'b1;
                        rescan  = 1'b1;
                    end
                end
                MODE_NUMBER:
                begin
                    if (is_digit(character))
                    begin
                        len_next = len_grow;
                    end
                    else
                    begin
                        flush_v = 1'b1;
                        rescan  = 1'b1;
                    end
                end
                MODE_COLON:
                begin
                    flush_v = 1'b1;
                    if (character == CH_EQUAL)
                    begin
                        flush_res.kind   = KIND_OP;
                        flush_res.length = 8'd2;
                        mode_next        = MODE_IDLE;
                    end
                    else
                    begin
                        rescan = 1'b1;
                    end
                end
                default:
                begin
                    rescan = 1'b1;
                end
            endcase

            if (rescan)
            begin
                mode_next             = MODE_IDLE;
                scan_res.value_char   = character;
                scan_res.start_offset = pos_reg;
                scan_res.length       = 8'd1;
                if (character inside {CH_SPACE, CH_TAB, CH_LF})
                begin
                    scan_v = 1'b0;
                end
                else if (is_letter(character) || is_digit(character) ||
                         character inside {CH_DOT, CH_PLUS, CH_MINUS, CH_COLON})
                begin
                    mode_next  = is_letter(character) ? MODE_IDENT :
                                 (character == CH_COLON) ? MODE_COLON : MODE_NUMBER;
                    start_next = pos_reg;
                    len_next   = LEN_W'(1);
                    first_next = character;
                    kw_next    = (character == CH_LOWER_F) ? KW_F :
                                 (character == CH_LOWER_D) ? KW_D : KW_NONE;
                end
                else if (character inside {CH_LPAREN, CH_RPAREN, CH_SEMI})
                begin
                    scan_v        = 1'b1;
                    scan_res.kind = KIND_DELIM;
                end
                else if (character inside {CH_LT, CH_GT, CH_EQUAL})
                begin
                    scan_v        = 1'b1;
                    scan_res.kind = KIND_OP;
                end
                else
                begin
                    scan_v        = 1'b1;
                    scan_res.kind = KIND_ERROR;
                end
            end
        end
    end

    assign push              = accept && (flush_v || scan_v);
    assign push_entry.two    = flush_v && scan_v;
    assign push_entry.first  = flush_v ? flush_res : scan_res;
    assign push_entry.second = scan_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            start_reg <= '0;
            len_reg   <= '0;
            first_reg <= '0;
            kw_reg    <= KW_NONE;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            first_reg <= first_next;
            kw_reg    <= kw_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

FILE: src/ctt_queue.sv
// ----------------------------------------------------------------------------
// ctt_queue
// Short entry queue between the scanner and the result emitter.
// ----------------------------------------------------------------------------
module ctt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ctt_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output ctt_pkg::entry_t head,
    output logic            empty
);
    import ctt_pkg::*;

    entry_t            entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg,  count_next;

    assign full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: src/ctt_emitter.sv
// ----------------------------------------------------------------------------
// ctt_emitter
// Back end: presents the results of the head entry one per request and marks
// the final one of each entry.
// ----------------------------------------------------------------------------
module ctt_emitter (
    input  logic            clk,
    input  logic            rst_n,
    input  ctt_pkg::entry_t head,
    input  logic            empty,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [2:0]      kind,
    output logic [7:0]      value_char,
    output logic [31:0]     start_offset,
    output logic [7:0]      length,
    output logic            last
);
    import ctt_pkg::*;

    logic    sel_reg, sel_next;
    result_t cur;
    logic    fire;

    assign out_valid    = !empty;
    assign cur          = sel_reg ? head.second : head.first;
    assign kind         = cur.kind;
    assign value_char   = cur.value_char;
    assign start_offset = cur.start_offset;
    assign length       = cur.length;
    assign last         = sel_reg || !head.two;
    assign fire         = out_valid && out_ready;
    assign pop          = fire && last;

    always_comb
    begin
        sel_next = sel_reg;
        if (fire)
            sel_next = !last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= 1'b0;
        else
            sel_reg <= sel_next;
    end

endmodule

FILE: src/char_stream_tokenizer_top.sv
// ----------------------------------------------------------------------------
// char_stream_tokenizer_top
// Streaming lexical analyzer: one byte per request in, token results out.
// ----------------------------------------------------------------------------
// The input side takes one request per cycle while the four-entry result queue
// has room; the scan state updates in that same cycle. A request makes zero,
// one or two results, and the output side drains them one per cycle while
// out_ready is high, so the sustained rate is one request per cycle if requests
// average at most one result; a request that ends one token and yields a second
// result costs an extra output transfer, absorbed by the queue. Results are
// registered in the queue and shown from its head. An end request flushes the
// pending token and restarts stream positions at zero.
module char_stream_tokenizer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  character,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  value_char,
    output logic [31:0] start_offset,
    output logic [7:0]  length,
    output logic        last
);
    import ctt_pkg::*;

    logic   push, pop, full, empty;
    entry_t push_entry, head;

    ctt_scanner u_scanner (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .character  (character),
        .queue_full (full),
        .push       (push),
        .push_entry (push_entry)
    );

    ctt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    ctt_emitter u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .value_char   (value_char),
        .start_offset (start_offset),
        .length       (length),
        .last         (last)
    );

endmodule

FILE: src/ctt_checker.sv
// ----------------------------------------------------------------------------
// ctt_checker
// Port-level checks on the tokenizer's result stream.
// ----------------------------------------------------------------------------
module ctt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  kind,
    input logic [7:0]  value_char,
    input logic [31:0] start_offset,
    input logic [7:0]  length,
    input logic        last
);
    import ctt_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(value_char) &&
        $stable(start_offset) && $stable(length) && $stable(last))
        else $error("result changed while stalled");

    a_assign_op: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_OP && length == 8'd2 |-> value_char == CH_COLON)
        else $error("two-character operation is not :=");

    a_single_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_DELIM || kind == KIND_ERROR) |-> length == 8'd1)
        else $error("delimiter or error with length other than one");

    a_keyword: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_KEYWORD |->
        (length == 8'd3 && value_char == CH_LOWER_F) ||
        (length == 8'd2 && value_char == CH_LOWER_D))
        else $error("keyword is neither for nor do");

endmodule

bind char_stream_tokenizer_top ctt_checker u_ctt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .value_char   (value_char),
    .start_offset (start_offset),
    .length       (length),
    .last         (last)
);

FILE: bench/token_checker.sv
// ----------------------------------------------------------------------------
// token_checker
// Watches both channels of the tokenizer, keeps its own scanner state, queues
// the tokens each accepted request should produce and compares every token
// that leaves the block, field by field, against the oldest one queued.
// ----------------------------------------------------------------------------
module token_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        action,
    input  logic [7:0]  character,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  kind,
    input  logic [7:0]  value_char,
    input  logic [31:0] start_offset,
    input  logic [7:0]  length,
    input  logic        last,
    output int          mismatches,
    output int          outstanding,
    output int          checked
);
    import ctt_pkg::*;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  value_char;
        logic [31:0] start_offset;
        logic [7:0]  length;
        logic        last;
    } token_t;

    scan_mode_t       mode_q;
    logic [31:0]      tok_start_q;
    logic [31:0]      pos_q;
    logic [LEN_W-1:0] tok_len_q;
    logic [7:0]       first_q;
    logic [2:0]       kw_q;

    token_t expected_tokens[$];
    token_t burst[$];

    int fail_total    = 0;
    int pending_total = 0;
    int checked_total = 0;

    assign mismatches  = fail_total;
    assign outstanding = pending_total;
    assign checked     = checked_total;

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        fail_total++;
    endtask

    function automatic logic word_char(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            || c == CH_UNDERSCORE;
    endfunction

    function automatic logic numeral(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic [2:0] advance_keyword(input logic [2:0] p, input logic [7:0] c);
        case (p)
            KW_F:    return (c == CH_LOWER_O) ? KW_FO : KW_NONE;
            KW_FO:   return (c == CH_LOWER_R) ? KW_FOR : KW_NONE;
            KW_D:    return (c == CH_LOWER_O) ? KW_DO : KW_NONE;
            default: return KW_NONE;
        endcase
    endfunction

    function automatic void reset_scanner();
        mode_q      = MODE_IDLE;
        tok_start_q = '0;
        tok_len_q   = '0;
        first_q     = '0;
        kw_q        = KW_NONE;
        pos_q       = '0;
    endfunction

    function automatic void emit_token(input logic [2:0] k, input logic [7:0] c,
                                       input logic [31:0] at, input int n);
        token_t t;
        t.kind         = k;
        t.value_char   = c;
        t.start_offset = at;
        t.length       = (n > 255) ? 8'hFF : n[7:0];
        t.last         = 1'b0;
        burst.push_back(t);
    endfunction

    function automatic void close_token();
        case (mode_q)
            MODE_IDENT:
                emit_token((kw_q == KW_FOR || kw_q == KW_DO) ? KIND_KEYWORD : KIND_IDENT,
                           first_q, tok_start_q, int'(tok_len_q));
            MODE_NUMBER:
                emit_token((tok_len_q == LEN_W'(1) &&
                            (first_q == CH_PLUS || first_q == CH_MINUS))
                           ? KIND_OP : KIND_NUMBER, first_q, tok_start_q, int'(tok_len_q));
            MODE_COLON:
                emit_token(KIND_ERROR, CH_COLON, tok_start_q, 1);
            default: ;
        endcase
        mode_q = MODE_IDLE;
    endfunction

    function automatic void open_token(input scan_mode_t m, input logic [7:0] c,
                                       input logic [31:0] at);
        mode_q      = m;
        tok_start_q = at;
        tok_len_q   = LEN_W'(1);
        first_q     = c;
        kw_q        = (c == CH_LOWER_F) ? KW_F : (c == CH_LOWER_D) ? KW_D : KW_NONE;
    endfunction

    function automatic void fresh_scan(input logic [7:0] c, input logic [31:0] at);
        if (c == CH_SPACE || c == CH_TAB || c == CH_LF)
            return;
        if (word_char(c))
            open_token(MODE_IDENT, c, at);
        else if (numeral(c) || c == CH_DOT || c == CH_PLUS || c == CH_MINUS)
            open_token(MODE_NUMBER, c, at);
        else if (c == CH_COLON)
            open_token(MODE_COLON, c, at);
        else if (c == CH_LPAREN || c == CH_RPAREN || c == CH_SEMI)
            emit_token(KIND_DELIM, c, at, 1);
        else if (c == CH_LT || c == CH_GT || c == CH_EQUAL)
            emit_token(KIND_OP, c, at, 1);
        else
            emit_token(KIND_ERROR, c, at, 1);
    endfunction

    function automatic void grow_token();
        if (int'(tok_len_q) < MAX_TOKEN_LEN)
            tok_len_q = tok_len_q + LEN_W'(1);
    endfunction

    function automatic void predict_tokens(input logic act, input logic [7:0] c);
        logic        again;
        logic [31:0] at;
        token_t      t;
        burst.delete();
        at = pos_q;
        if (act == ACT_END)
        begin
            close_token();
            reset_scanner();
        end
        else
        begin
            again = 1'b1;
            case (mode_q)
                MODE_IDENT:
                    if (word_char(c) || numeral(c))
                    begin
                        grow_token();
                        kw_q  = advance_keyword(kw_q, c);
                        again = 1'b0;
                    end
                    else
                        close_token();
                MODE_NUMBER:
                    if (numeral(c))
                    begin
                        grow_token();
                        again = 1'b0;
                    end
                    else
                        close_token();
                MODE_COLON:
                    if (c == CH_EQUAL)
                    begin
                        emit_token(KIND_OP, CH_COLON, tok_start_q, 2);
                        mode_q = MODE_IDLE;
                        again  = 1'b0;
                    end
                    else
                        close_token();
                default: ;
            endcase
            if (again)
                fresh_scan(c, at);
            pos_q = at + 32'd1;
        end
        if (burst.size() > 0)
        begin
            t      = burst.pop_back();
            t.last = 1'b1;
            burst.push_back(t);
        end
        foreach (burst[i])
            expected_tokens.push_back(burst[i]);
    endfunction

    initial reset_scanner();

    always @(posedge clk)
    begin
        token_t want;
        if (!rst_n)
        begin
            reset_scanner();
            expected_tokens.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                checked_total++;
                if (expected_tokens.size() == 0)
                    report_mismatch($sformatf("unexpected token kind %0d char %02h at %0d",
                                              kind, value_char, start_offset));
                else
                begin
                    want = expected_tokens.pop_front();
                    if (kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d (token at %0d)",
                                                  kind, want.kind, want.start_offset));
                    if (value_char !== want.value_char)
                        report_mismatch($sformatf("value_char %02h, want %02h (token at %0d)",
                                                  value_char, want.value_char,
                                                  want.start_offset));
                    if (start_offset !== want.start_offset)
                        report_mismatch($sformatf("start_offset %0d, want %0d",
                                                  start_offset, want.start_offset));
                    if (length !== want.length)
                        report_mismatch($sformatf("length %0d, want %0d (token at %0d)",
                                                  length, want.length, want.start_offset));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b (token at %0d)",
                                                  last, want.last, want.start_offset));
                end
            end
            if (in_valid && in_ready)
                predict_tokens(action, character);
        end
        pending_total = expected_tokens.size();
    end

endmodule

FILE: bench/tb_char_stream_tokenizer_top.sv
// ----------------------------------------------------------------------------
// tb_char_stream_tokenizer_top
// Drives the tokenizer with a directed set of lexical corner cases, then with
// random token fragments, noise bytes and flushes under random idling on both
// sides plus one long receiver hold-off; the checker judges every token.
// ----------------------------------------------------------------------------
module tb_char_stream_tokenizer_top;
    import ctt_pkg::*;

    localparam int          RANDOM_ITEMS = 1400;
    localparam int          HOLD_CYCLES  = 60;
    localparam int          DRAIN_CYCLES = 8;
    localparam longint      TIMEOUT      = 64'd4_000_000;
    localparam logic [7:0]  CH_CR        = 8'h0D;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        action    = ACT_CHAR;
    logic [7:0]  character = 8'h00;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [2:0]  kind;
    logic [7:0]  value_char;
    logic [31:0] start_offset;
    logic [7:0]  length;
    logic        last;

    int mismatches;
    int outstanding;
    int checked;

    int requests     = 0;
    int flushes      = 0;
    int hold_count   = 0;
    int long_tokens  = 0;
    bit calm         = 1'b0;
    bit hold_request = 1'b0;

    always #10 clk = ~clk;

    char_stream_tokenizer_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .character    (character),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .value_char   (value_char),
        .start_offset (start_offset),
        .length       (length),
        .last         (last)
    );

    token_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .character    (character),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .value_char   (value_char),
        .start_offset (start_offset),
        .length       (length),
        .last         (last),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .checked      (checked)
    );

    // handshake is sampled at the falling edge, where everything is settled
    task automatic push_request(input logic act, input logic [7:0] c);
        bit granted;
        if (!calm && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        character <= c;
        do
        begin
            @(negedge clk);
            granted = in_ready;
            @(posedge clk);
        end
        while (!granted);
        requests++;
    endtask

    task automatic send_char(input logic [7:0] c);
        push_request(ACT_CHAR, c);
    endtask

    task automatic send_end();
        push_request(ACT_END, 8'($urandom_range(0, 255)));
        flushes++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    function automatic logic [7:0] pick_word_char(input bit lead);
        int r;
        r = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
        if (r < 26)
            return CH_LOWER_A + r[7:0];
        if (r < 52)
            return CH_UPPER_A + r[7:0] - 8'd26;
        if (r == 52)
            return CH_UNDERSCORE;
        return CH_0 + r[7:0] - 8'd53;
    endfunction

    function automatic logic [7:0] pick_digit();
        return CH_0 + 8'($urandom_range(0, 9));
    endfunction

    // identifier or number well past the saturation point
    task automatic send_long(input bit as_number);
        int n;
        n = $urandom_range(256, 300);
        send_char(as_number ? CH_PLUS : pick_word_char(1'b1));
        repeat (n - 1)
            send_char(as_number ? pick_digit() : pick_word_char(1'b0));
        long_tokens++;
    endtask

    task automatic send_fragment();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            case ($urandom_range(0, 7))
                0: send_text("for");
                1: send_text("do");
                2: send_text("f");
                3: send_text("fo");
                4: send_text("d");
                5: send_text("forx");
                6: send_text("dor");
                default: send_text("FOR");
            endcase
        end
        else if (pick < 30)
        begin
            n = $urandom_range(1, 8);
            send_char(pick_word_char(1'b1));
            repeat (n - 1)
                send_char(pick_word_char(1'b0));
        end
        else if (pick < 48)
        begin
            case ($urandom_range(0, 3))
                0: send_char(pick_digit());
                1: send_char(CH_DOT);
                2: send_char(CH_PLUS);
                default: send_char(CH_MINUS);
            endcase
            repeat ($urandom_range(0, 6))
                send_char(pick_digit());
        end
        else if (pick < 56)
        begin
            send_char(CH_COLON);
            if ($urandom_range(0, 99) < 60)
                send_char(CH_EQUAL);
        end
        else if (pick < 70)
        begin
            case ($urandom_range(0, 7))
                0: send_char(CH_LPAREN);
                1: send_char(CH_RPAREN);
                2: send_char(CH_SEMI);
                3: send_char(CH_LT);
                4: send_char(CH_GT);
                5: send_char(CH_EQUAL);
                6: send_char(CH_PLUS);
                default: send_char(CH_MINUS);
            endcase
        end
        else if (pick < 82)
        begin
            repeat ($urandom_range(1, 3))
            begin
                case ($urandom_range(0, 2))
                    0: send_char(CH_SPACE);
                    1: send_char(CH_TAB);
                    default: send_char(CH_LF);
                endcase
            end
        end
        else if (pick < 96)
            send_char(8'($urandom_range(0, 255)));
        else
            send_end();
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                hold_count++;
            end
            else
                out_ready <= calm || ($urandom_range(0, 99) >= 20);
        end
    end

    initial
    begin
        #(TIMEOUT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int  base;
        bit  hold_done;
        hold_done = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("for ");
        send_text("do(");
        send_text(":=");
        send_text(":;");
        send_text("+9-");
        send_char(CH_TAB);
        send_char(CH_DOT);
        send_char(CH_CR);
        send_text("<>=)");
        send_char(8'hFF);
        send_char(8'h00);
        send_text("_Zz9");
        send_end();
        send_end();
        send_char(CH_COLON);
        send_end();

        base = requests;
        while (requests - base < RANDOM_ITEMS)
        begin
            calm = (requests - base >= 500) && (requests - base < 800);
            if (!hold_done && requests - base >= 300)
            begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (long_tokens < 2 && requests - base >= 200 + 700 * long_tokens)
                send_long(long_tokens[0]);
            else
                send_fragment();
        end
        calm = 1'b0;
        send_end();
        in_valid <= 1'b0;

        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests (%0d end-of-input flushes), %0d tokens compared",
                 requests, flushes, checked);
        $display("with %0d saturating long tokens and %0d receiver hold-off(s) of %0d cycles",
                 long_tokens, hold_count, HOLD_CYCLES);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
